/* rtl/core/dataflash_spi_command_sequencer_unit_defines.svh */
// ----------------------------------------------------------------------------
// dataflash_spi_command_sequencer_unit_defines
// Assertion macros shared by the command sequencer modules.
// ----------------------------------------------------------------------------
`ifndef DATAFLASH_SPI_COMMAND_SEQUENCER_UNIT_DEFINES_SVH
`define DATAFLASH_SPI_COMMAND_SEQUENCER_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DFSQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DFSQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/dfsq_pkg.sv */
// ----------------------------------------------------------------------------
// dfsq_pkg
// Types, codes and constants of the dataflash SPI command sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package dfsq_pkg;

    // Flash geometry and request limit
    localparam int PAGE_BYTES   = 264;
    localparam int PAGE_COUNT   = 4096;
    localparam int OFFSET_LIMIT = 1081344;

    localparam int OFFSET_W = 21;
    localparam int LEN_W    = 21;
    localparam int PAGE_W   = $clog2(PAGE_COUNT);
    localparam int COL_W    = 9;
    localparam int QUOT_W   = 13;

    // offset / PAGE_BYTES = (offset >> 3) / (PAGE_BYTES / 8), by reciprocal
    localparam int DIV_PRE_SHIFT = 3;
    localparam int DIV_DIVISOR   = PAGE_BYTES / 8;
    localparam int DIV_SHIFT     = 23;
    localparam int DIV_IN_W      = OFFSET_W - DIV_PRE_SHIFT;
    localparam int DIV_MULT_W    = 18;
    localparam int DIV_PROD_W    = DIV_IN_W + DIV_MULT_W;
    localparam int DIV_MULT      = (2 ** DIV_SHIFT + DIV_DIVISOR - 1) / DIV_DIVISOR;

    // Request codes
    localparam logic [1:0] OP_READ      = 2'd0;
    localparam logic [1:0] OP_WRITE     = 2'd1;
    localparam logic [1:0] OP_SPI_BYTE  = 2'd2;
    localparam logic [1:0] OP_HOST_BYTE = 2'd3;

    // Result codes
    localparam logic [2:0] ACT_ASSERT  = 3'd0;
    localparam logic [2:0] ACT_XFER    = 3'd1;
    localparam logic [2:0] ACT_RELEASE = 3'd2;
    localparam logic [2:0] ACT_RDATA   = 3'd3;
    localparam logic [2:0] ACT_NEED    = 3'd4;
    localparam logic [2:0] ACT_DONE    = 3'd5;
    localparam logic [2:0] ACT_REJECT  = 3'd6;

    // Configuration register indexes and reset values
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_STATUS_OP = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_OP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_P2B_OP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BWR_OP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RWR_OP    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FILLER    = 3'd5;

    localparam logic [7:0] RST_STATUS_OP = 8'd215;
    localparam logic [7:0] RST_READ_OP   = 8'd210;
    localparam logic [7:0] RST_P2B_OP    = 8'd83;
    localparam logic [7:0] RST_BWR_OP    = 8'd132;
    localparam logic [7:0] RST_RWR_OP    = 8'd88;
    localparam logic [7:0] RST_FILLER    = 8'd0;

    // Results of one item, slot 0 first
    localparam int BND_SLOTS = 3;
    localparam int BND_CNT_W = 2;
    localparam int BND_IDX_W = 2;

    typedef struct packed {
        logic [1:0]          op;
        logic [OFFSET_W-1:0] offset;
        logic [LEN_W-1:0]    length;
        logic [7:0]          data;
    } t_in_item;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] byte_value;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic [7:0] status_opcode;
        logic [7:0] page_read_opcode;
        logic [7:0] page_to_buffer_opcode;
        logic [7:0] buffer_write_opcode;
        logic [7:0] rewrite_opcode;
        logic [7:0] filler_byte;
    } t_cfg;

    typedef struct packed {
        logic [BND_CNT_W-1:0]       count;
        logic [BND_SLOTS-1:0][2:0]  act;
        logic [BND_SLOTS-1:0][7:0]  val;
    } t_bundle;

endpackage

`default_nettype wire

/* rtl/core/dfsq_cfg.sv */
// ----------------------------------------------------------------------------
// dfsq_cfg
// Opcode and filler byte registers with a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module dfsq_cfg (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [dfsq_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [7:0]                      i_cfg_data,
    output dfsq_pkg::t_cfg                       o_cfg
);
    import dfsq_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.status_opcode         <= RST_STATUS_OP;
            r_cfg.page_read_opcode      <= RST_READ_OP;
            r_cfg.page_to_buffer_opcode <= RST_P2B_OP;
            r_cfg.buffer_write_opcode   <= RST_BWR_OP;
            r_cfg.rewrite_opcode        <= RST_RWR_OP;
            r_cfg.filler_byte           <= RST_FILLER;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_STATUS_OP: r_cfg.status_opcode         <= i_cfg_data;
                CFG_READ_OP:   r_cfg.page_read_opcode      <= i_cfg_data;
                CFG_P2B_OP:    r_cfg.page_to_buffer_opcode <= i_cfg_data;
                CFG_BWR_OP:    r_cfg.buffer_write_opcode   <= i_cfg_data;
                CFG_RWR_OP:    r_cfg.rewrite_opcode        <= i_cfg_data;
                CFG_FILLER:    r_cfg.filler_byte           <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

/* rtl/core/dfsq_engine.sv */
// ----------------------------------------------------------------------------
// dfsq_engine
// Input register, sequencer state and the single-pass step logic.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dataflash_spi_command_sequencer_unit_defines.svh"

module dfsq_engine (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire dfsq_pkg::t_in_item i_item,
    input  wire dfsq_pkg::t_cfg     i_cfg,
    output logic                    o_bvalid,
    input  wire logic               i_bready,
    output dfsq_pkg::t_bundle       o_bundle
);
    import dfsq_pkg::*;

    localparam logic [3:0] PH_IDLE      = 4'd0;
    localparam logic [3:0] PH_POLL_OP   = 4'd1;
    localparam logic [3:0] PH_POLL_RD   = 4'd2;
    localparam logic [3:0] PH_HDR_READ  = 4'd3;
    localparam logic [3:0] PH_HDR_P2B   = 4'd4;
    localparam logic [3:0] PH_HDR_BWR   = 4'd5;
    localparam logic [3:0] PH_HDR_RWR   = 4'd6;
    localparam logic [3:0] PH_READ_DATA = 4'd7;
    localparam logic [3:0] PH_WAIT_HOST = 4'd8;
    localparam logic [3:0] PH_WDATA     = 4'd9;

    localparam logic [1:0] HDR_LAST = 2'd3;

    // Input register, with the page quotient worked out on the way in
    logic                 r_in_valid;
    t_in_item             r_in;
    logic [QUOT_W-1:0]    r_quot;
    logic [DIV_PROD_W-1:0] quot_prod;
    logic                 fire;

    // Sequencer state
    logic [3:0]           r_phase,  n_phase;
    logic [3:0]           r_ret,    n_ret;
    logic [PAGE_W-1:0]    r_page,   n_page;
    logic [COL_W-1:0]     r_column, n_column;
    logic [LEN_W-1:0]     r_left,   n_left;
    logic [1:0]           r_hidx,   n_hidx;

    logic [OFFSET_W-1:0]  col_full;
    logic [LEN_W-1:0]     left_dec;
    logic [COL_W-1:0]     col_inc;
    logic                 uses_col;
    logic [COL_W-1:0]     hcol;
    logic [7:0]           hbyte;
    logic [7:0]           ret_opcode;
    t_bundle              bnd;

    assign quot_prod = DIV_PROD_W'(i_item.offset[OFFSET_W-1:DIV_PRE_SHIFT])
                     * DIV_PROD_W'(DIV_MULT);

    assign fire    = r_in_valid && i_bready;
    assign o_stall = r_in_valid && !i_bready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && !o_stall) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in   <= i_item;
            r_quot <= quot_prod[DIV_PROD_W-1 -: QUOT_W];
        end
    end

    // Remainder and counters
    assign col_full = r_in.offset - OFFSET_W'(OFFSET_W'(r_quot) * OFFSET_W'(PAGE_BYTES));
    assign left_dec = r_left - LEN_W'(1);
    assign col_inc  = r_column + COL_W'(1);

    // Address bytes of the current command header
    assign uses_col = (r_phase == PH_HDR_READ) || (r_phase == PH_HDR_BWR);
    assign hcol     = uses_col ? r_column : '0;

    always_comb begin
        case (r_hidx)
            2'd0:    hbyte = 8'(r_page >> 7);
            2'd1:    hbyte = {r_page[6:0], hcol[COL_W-1]};
            default: hbyte = uses_col ? hcol[7:0] : i_cfg.filler_byte;
        endcase
    end

    always_comb begin
        if (r_ret == PH_HDR_READ) begin
            ret_opcode = i_cfg.page_read_opcode;
        end else if (r_ret == PH_HDR_P2B) begin
            ret_opcode = i_cfg.page_to_buffer_opcode;
        end else if (r_ret == PH_HDR_BWR) begin
            ret_opcode = i_cfg.buffer_write_opcode;
        end else begin
            ret_opcode = i_cfg.rewrite_opcode;
        end
    end

    // One step per item: next state and the results it causes
    always_comb begin
        n_phase  = r_phase;
        n_ret    = r_ret;
        n_page   = r_page;
        n_column = r_column;
        n_left   = r_left;
        n_hidx   = r_hidx;
        bnd      = '0;
        unique case (r_phase) inside
            PH_IDLE: begin
                if (r_in.op == OP_READ || r_in.op == OP_WRITE) begin
                    if (r_in.offset > OFFSET_W'(OFFSET_LIMIT)) begin
                        bnd.count  = 2'd1;
                        bnd.act[0] = ACT_REJECT;
                    end else if (r_in.op == OP_WRITE && r_in.length == '0) begin
                        bnd.count  = 2'd1;
                        bnd.act[0] = ACT_DONE;
                    end else begin
                        n_page     = r_quot[PAGE_W-1:0];
                        n_column   = col_full[COL_W-1:0];
                        n_left     = r_in.length;
                        n_hidx     = '0;
                        n_phase    = PH_POLL_OP;
                        n_ret      = (r_in.op == OP_WRITE) ? PH_HDR_P2B : PH_HDR_READ;
                        bnd.count  = 2'd2;
                        bnd.act[0] = ACT_ASSERT;
                        bnd.act[1] = ACT_XFER;
                        bnd.val[1] = i_cfg.status_opcode;
                    end
                end
            end
            PH_WAIT_HOST: begin
                if (r_in.op == OP_HOST_BYTE) begin
                    bnd.count  = 2'd1;
                    bnd.act[0] = ACT_XFER;
                    bnd.val[0] = r_in.data;
                    n_phase    = PH_WDATA;
                end
            end
            PH_POLL_OP: begin
                if (r_in.op == OP_SPI_BYTE) begin
                    bnd.count  = 2'd1;
                    bnd.act[0] = ACT_XFER;
                    bnd.val[0] = i_cfg.filler_byte;
                    n_phase    = PH_POLL_RD;
                end
            end
            PH_POLL_RD: begin
                if (r_in.op == OP_SPI_BYTE) begin
                    if (r_in.data[7]) begin
                        bnd.count  = 2'd3;
                        bnd.act[0] = ACT_RELEASE;
                        bnd.act[1] = ACT_ASSERT;
                        bnd.act[2] = ACT_XFER;
                        bnd.val[2] = ret_opcode;
                        n_phase    = r_ret;
                        n_hidx     = '0;
                    end else begin
                        bnd.count  = 2'd1;
                        bnd.act[0] = ACT_XFER;
                        bnd.val[0] = i_cfg.filler_byte;
                    end
                end
            end
            PH_HDR_READ, PH_HDR_P2B, PH_HDR_BWR, PH_HDR_RWR: begin
                if (r_in.op == OP_SPI_BYTE) begin
                    if (r_hidx != HDR_LAST) begin
                        bnd.count  = 2'd1;
                        bnd.act[0] = ACT_XFER;
                        bnd.val[0] = hbyte;
                        n_hidx     = r_hidx + 2'd1;
                    end else if (r_phase == PH_HDR_READ) begin
                        if (r_left != '0) begin
                            bnd.count  = 2'd1;
                            bnd.act[0] = ACT_XFER;
                            bnd.val[0] = i_cfg.filler_byte;
                            n_phase    = PH_READ_DATA;
                        end else begin
                            bnd.count  = 2'd2;
                            bnd.act[0] = ACT_RELEASE;
                            bnd.act[1] = ACT_DONE;
                            n_phase    = PH_IDLE;
                        end
                    end else if (r_phase == PH_HDR_P2B) begin
                        bnd.count  = 2'd3;
                        bnd.act[0] = ACT_RELEASE;
                        bnd.act[1] = ACT_ASSERT;
                        bnd.act[2] = ACT_XFER;
                        bnd.val[2] = i_cfg.status_opcode;
                        n_phase    = PH_POLL_OP;
                        n_ret      = PH_HDR_BWR;
                    end else if (r_phase == PH_HDR_BWR) begin
                        bnd.count  = 2'd1;
                        bnd.act[0] = ACT_NEED;
                        n_phase    = PH_WAIT_HOST;
                    end else if (r_left != '0) begin
                        // page committed, move on to the next one
                        bnd.count  = 2'd3;
                        bnd.act[0] = ACT_RELEASE;
                        bnd.act[1] = ACT_ASSERT;
                        bnd.act[2] = ACT_XFER;
                        bnd.val[2] = i_cfg.status_opcode;
                        n_column   = '0;
                        n_page     = r_page + PAGE_W'(1);
                        n_phase    = PH_POLL_OP;
                        n_ret      = PH_HDR_P2B;
                    end else begin
                        bnd.count  = 2'd2;
                        bnd.act[0] = ACT_RELEASE;
                        bnd.act[1] = ACT_DONE;
                        n_phase    = PH_IDLE;
                    end
                end
            end
            PH_READ_DATA: begin
                if (r_in.op == OP_SPI_BYTE) begin
                    n_left     = left_dec;
                    bnd.act[0] = ACT_RDATA;
                    bnd.val[0] = r_in.data;
                    if (left_dec != '0) begin
                        bnd.count  = 2'd2;
                        bnd.act[1] = ACT_XFER;
                        bnd.val[1] = i_cfg.filler_byte;
                    end else begin
                        bnd.count  = 2'd3;
                        bnd.act[1] = ACT_RELEASE;
                        bnd.act[2] = ACT_DONE;
                        n_phase    = PH_IDLE;
                    end
                end
            end
            PH_WDATA: begin
                if (r_in.op == OP_SPI_BYTE) begin
                    n_left   = left_dec;
                    n_column = col_inc;
                    if (col_inc < COL_W'(PAGE_BYTES) && left_dec != '0) begin
                        bnd.count  = 2'd1;
                        bnd.act[0] = ACT_NEED;
                        n_phase    = PH_WAIT_HOST;
                    end else begin
                        bnd.count  = 2'd3;
                        bnd.act[0] = ACT_RELEASE;
                        bnd.act[1] = ACT_ASSERT;
                        bnd.act[2] = ACT_XFER;
                        bnd.val[2] = i_cfg.status_opcode;
                        n_phase    = PH_POLL_OP;
                        n_ret      = PH_HDR_RWR;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_ret    <= PH_IDLE;
            r_page   <= '0;
            r_column <= '0;
            r_left   <= '0;
            r_hidx   <= '0;
        end else if (fire) begin
            r_phase  <= n_phase;
            r_ret    <= n_ret;
            r_page   <= n_page;
            r_column <= n_column;
            r_left   <= n_left;
            r_hidx   <= n_hidx;
        end
    end

    assign o_bvalid = fire && (bnd.count != '0);
    assign o_bundle = bnd;

    `DFSQ_ASSERT_NOW(a_wait_col, r_phase == PH_WAIT_HOST,
        r_column < COL_W'(PAGE_BYTES), "host byte requested past page end")
    `DFSQ_ASSERT_NOW(a_read_left, r_phase == PH_READ_DATA, r_left != '0,
        "read data phase with nothing left")
    `DFSQ_ASSERT_NOW(a_poll_ret, r_phase == PH_POLL_OP || r_phase == PH_POLL_RD,
        r_ret == PH_HDR_READ || r_ret == PH_HDR_P2B || r_ret == PH_HDR_BWR
            || r_ret == PH_HDR_RWR,
        "poll without a command to return to")

endmodule

`default_nettype wire

/* rtl/core/dfsq_out.sv */
// ----------------------------------------------------------------------------
// dfsq_out
// Result register: holds the results of one item and hands them out in order.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dataflash_spi_command_sequencer_unit_defines.svh"

module dfsq_out (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_bvalid,
    output logic                    o_bready,
    input  wire dfsq_pkg::t_bundle  i_bundle,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output dfsq_pkg::t_out_item     o_item
);
    import dfsq_pkg::*;

    logic                 r_bvalid;
    t_bundle              r_bundle;
    logic [BND_IDX_W-1:0] r_idx;
    logic                 idx_last;

    assign idx_last = (r_idx == BND_IDX_W'(r_bundle.count - BND_CNT_W'(1)));
    assign o_bready = !r_bvalid || (!i_stall && idx_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bvalid <= 1'b0;
            r_idx    <= '0;
        end else if (i_bvalid && o_bready) begin
            r_bvalid <= 1'b1;
            r_idx    <= '0;
        end else if (r_bvalid && !i_stall) begin
            if (idx_last) begin
                r_bvalid <= 1'b0;
            end else begin
                r_idx <= r_idx + BND_IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_bvalid && o_bready) begin
            r_bundle <= i_bundle;
        end
    end

    assign o_valid           = r_bvalid;
    assign o_item.action     = r_bundle.act[r_idx];
    assign o_item.byte_value = r_bundle.val[r_idx];
    assign o_item.last       = idx_last;

    `DFSQ_ASSERT_NOW(a_idx_range, r_bvalid, BND_CNT_W'(r_idx) < r_bundle.count,
        "result index beyond item's results")
    `DFSQ_ASSERT_NOW(a_no_empty, i_bvalid, i_bundle.count != '0, "empty result group offered")
    `DFSQ_ASSERT_NEXT(a_hold, r_bvalid && i_stall, r_bvalid && $stable(r_idx),
        "stalled result moved")

endmodule

`default_nettype wire

/* rtl/core/dataflash_spi_command_sequencer_unit.sv */
// Path: an accepted item passes the input register, then the result register, which shows
//   its results one a cycle while not stalled; an item may yield up to three results or none.
// Throughput: one item a cycle while items yield at most one result and output is unstalled;
//   else the output channel paces at one result a cycle, one item held in the input register.
// Reset: synchronous, active low; clears the sequencer to idle and the registers to defaults.
// ----------------------------------------------------------------------------
// dataflash_spi_command_sequencer_unit
// SPI command sequencer for a serial dataflash with 264-byte pages.
// ----------------------------------------------------------------------------
`default_nettype none

// Structure:
//   dfsq_cfg    - opcode and filler byte registers, written from the plain port.
//   dfsq_engine - input register (page quotient taken on the way in by a reciprocal
//                 multiply), sequencer state and the step logic that turns one item
//                 into a group of results.
//   dfsq_out    - result register holding one group; hands its results out one at a
//                 time and frees for the next group on the last one.
//
// The engine steps an item only when the result register can take its group, so the
// state advances exactly once per item and no result is dropped under stall. Items that
// cause no result pass through without using the result register.

module dataflash_spi_command_sequencer_unit (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // configuration
    input  wire logic                            i_cfg_we,
    input  wire logic [dfsq_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [7:0]                      i_cfg_data,
    // request channel
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire dfsq_pkg::t_in_item              i_in_item,
    // result channel
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output dfsq_pkg::t_out_item                  o_out_item
);
    import dfsq_pkg::*;

    t_cfg    cfg;
    t_bundle bundle;
    logic    bundle_valid;
    logic    bundle_ready;

    // Hold the register set
    dfsq_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Advance the sequencer by one item
    dfsq_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .o_stall  (o_in_stall),
        .i_item   (i_in_item),
        .i_cfg    (cfg),
        .o_bvalid (bundle_valid),
        .i_bready (bundle_ready),
        .o_bundle (bundle)
    );

    // Drain the result group in order
    dfsq_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_bvalid (bundle_valid),
        .o_bready (bundle_ready),
        .i_bundle (bundle),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_item   (o_out_item)
    );

endmodule

`default_nettype wire

/* tb/dfsq_result_checker.sv */
// ----------------------------------------------------------------------------
// dfsq_result_checker
// Watches the request, result and register ports of the command sequencer,
// predicts the result items of every accepted request and checks them in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dfsq_result_checker
    import dfsq_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [7:0]            i_cfg_data,
    input  wire logic                  i_in_valid,
    input  wire logic                  i_in_stall,
    input  t_in_item                   i_in_item,
    input  wire logic                  i_out_valid,
    input  wire logic                  i_out_stall,
    input  t_out_item                  i_out_item,
    output int                         o_fail_count,
    output int                         o_pending,
    output int                         o_checked
);

    typedef enum logic [4:0] {
        SQ_IDLE,
        SQ_POLL_OP,
        SQ_POLL_RD,
        SQ_HDR_READ,
        SQ_HDR_P2B,
        SQ_HDR_BWR,
        SQ_HDR_RWR,
        SQ_READ_DATA,
        SQ_WAIT_HOST,
        SQ_WDATA
    } t_seq_phase;

    // Own copy of the register file and of the sequencer state
    t_cfg              cfg;
    t_seq_phase        seq_phase;
    t_seq_phase        resume_phase;
    logic [PAGE_W-1:0] page_no;
    logic [COL_W-1:0]  col;
    logic [LEN_W-1:0]  remaining;
    logic [1:0]        hdr_idx;

    t_out_item expected_results[$];
    t_out_item group_buf[$];
    int        fail_total    = 0;
    int        checked_total = 0;

    function automatic void note_result(input logic [2:0] action, input logic [7:0] value);
        t_out_item r;
        r.action     = action;
        r.byte_value = value;
        r.last       = 1'b0;
        group_buf.push_back(r);
    endfunction

    function automatic void begin_poll(input t_seq_phase next);
        note_result(ACT_ASSERT, 8'h00);
        note_result(ACT_XFER, cfg.status_opcode);
        seq_phase    = SQ_POLL_OP;
        resume_phase = next;
    endfunction

    function automatic logic [7:0] command_opcode(input t_seq_phase ph);
        case (ph)
            SQ_HDR_READ: return cfg.page_read_opcode;
            SQ_HDR_P2B:  return cfg.page_to_buffer_opcode;
            SQ_HDR_BWR:  return cfg.buffer_write_opcode;
            default:     return cfg.rewrite_opcode;
        endcase
    endfunction

    // Page-to-buffer and rewrite address column 0 and pad the last byte
    function automatic logic [7:0] address_byte(input t_seq_phase ph, input logic [1:0] idx);
        logic             with_col;
        logic [COL_W-1:0] c;
        with_col = (ph == SQ_HDR_READ || ph == SQ_HDR_BWR);
        c        = with_col ? col : '0;
        case (idx)
            2'd0:    return 8'(page_no >> 7);
            2'd1:    return {page_no[6:0], 1'b0} + 8'(c >> 8);
            default: return with_col ? c[7:0] : cfg.filler_byte;
        endcase
    endfunction

    function automatic void finish_header();
        case (seq_phase)
            SQ_HDR_READ: begin
                if (remaining != '0) begin
                    note_result(ACT_XFER, cfg.filler_byte);
                    seq_phase = SQ_READ_DATA;
                end else begin
                    note_result(ACT_RELEASE, 8'h00);
                    note_result(ACT_DONE, 8'h00);
                    seq_phase = SQ_IDLE;
                end
            end
            SQ_HDR_P2B: begin
                note_result(ACT_RELEASE, 8'h00);
                begin_poll(SQ_HDR_BWR);
            end
            SQ_HDR_BWR: begin
                note_result(ACT_NEED, 8'h00);
                seq_phase = SQ_WAIT_HOST;
            end
            default: begin
                note_result(ACT_RELEASE, 8'h00);
                if (remaining != '0) begin
                    col     = '0;
                    page_no = PAGE_W'((int'(page_no) + 1) % PAGE_COUNT);
                    begin_poll(SQ_HDR_P2B);
                end else begin
                    note_result(ACT_DONE, 8'h00);
                    seq_phase = SQ_IDLE;
                end
            end
        endcase
    endfunction

    function automatic void step_sequencer(input t_in_item it);
        int unsigned off;
        t_out_item   r;
        off = it.offset;
        group_buf.delete();
        if (seq_phase == SQ_IDLE) begin
            if (it.op == OP_READ || it.op == OP_WRITE) begin
                if (off > OFFSET_LIMIT) begin
                    note_result(ACT_REJECT, 8'h00);
                end else if (it.op == OP_WRITE && it.length == '0) begin
                    note_result(ACT_DONE, 8'h00);
                end else begin
                    page_no   = PAGE_W'((off / PAGE_BYTES) % PAGE_COUNT);
                    col       = COL_W'(off % PAGE_BYTES);
                    remaining = it.length;
                    hdr_idx   = '0;
                    begin_poll(it.op == OP_WRITE ? SQ_HDR_P2B : SQ_HDR_READ);
                end
            end
        end else if (seq_phase == SQ_WAIT_HOST) begin
            if (it.op == OP_HOST_BYTE) begin
                note_result(ACT_XFER, it.data);
                seq_phase = SQ_WDATA;
            end
        end else if (it.op == OP_SPI_BYTE) begin
            case (seq_phase)
                SQ_POLL_OP: begin
                    note_result(ACT_XFER, cfg.filler_byte);
                    seq_phase = SQ_POLL_RD;
                end
                SQ_POLL_RD: begin
                    // Ready bit set: close the poll and open the command
                    if (it.data[7]) begin
                        note_result(ACT_RELEASE, 8'h00);
                        note_result(ACT_ASSERT, 8'h00);
                        seq_phase = resume_phase;
                        hdr_idx   = '0;
                        note_result(ACT_XFER, command_opcode(seq_phase));
                    end else begin
                        note_result(ACT_XFER, cfg.filler_byte);
                    end
                end
                SQ_HDR_READ, SQ_HDR_P2B, SQ_HDR_BWR, SQ_HDR_RWR: begin
                    if (hdr_idx < 2'd3) begin
                        note_result(ACT_XFER, address_byte(seq_phase, hdr_idx));
                        hdr_idx = hdr_idx + 2'd1;
                    end else begin
                        finish_header();
                    end
                end
                SQ_READ_DATA: begin
                    note_result(ACT_RDATA, it.data);
                    remaining = remaining - 1'b1;
                    if (remaining != '0) begin
                        note_result(ACT_XFER, cfg.filler_byte);
                    end else begin
                        note_result(ACT_RELEASE, 8'h00);
                        note_result(ACT_DONE, 8'h00);
                        seq_phase = SQ_IDLE;
                    end
                end
                SQ_WDATA: begin
                    remaining = remaining - 1'b1;
                    col       = col + 1'b1;
                    if (col < PAGE_BYTES && remaining != '0) begin
                        note_result(ACT_NEED, 8'h00);
                        seq_phase = SQ_WAIT_HOST;
                    end else begin
                        note_result(ACT_RELEASE, 8'h00);
                        begin_poll(SQ_HDR_RWR);
                    end
                end
                default: ;
            endcase
        end
        foreach (group_buf[i]) begin
            r      = group_buf[i];
            r.last = (i == group_buf.size() - 1);
            expected_results.push_back(r);
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_out_item want;
        if (!i_rst_n) begin
            cfg          = '{RST_STATUS_OP, RST_READ_OP, RST_P2B_OP,
                             RST_BWR_OP, RST_RWR_OP, RST_FILLER};
            seq_phase    = SQ_IDLE;
            resume_phase = SQ_IDLE;
            page_no      = '0;
            col          = '0;
            remaining    = '0;
            hdr_idx      = '0;
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_STATUS_OP: cfg.status_opcode         = i_cfg_data;
                    CFG_READ_OP:   cfg.page_read_opcode      = i_cfg_data;
                    CFG_P2B_OP:    cfg.page_to_buffer_opcode = i_cfg_data;
                    CFG_BWR_OP:    cfg.buffer_write_opcode   = i_cfg_data;
                    CFG_RWR_OP:    cfg.rewrite_opcode        = i_cfg_data;
                    CFG_FILLER:    cfg.filler_byte           = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result item: action %0d byte 0x%02h last %0b",
                           i_out_item.action, i_out_item.byte_value, i_out_item.last);
                    fail_total++;
                end else begin
                    want = expected_results.pop_front();
                    checked_total++;
                    if (i_out_item.action !== want.action) begin
                        $error("action: expected %0d, actual %0d",
                               want.action, i_out_item.action);
                        fail_total++;
                    end
                    if (i_out_item.byte_value !== want.byte_value) begin
                        $error("byte_value: expected 0x%02h, actual 0x%02h",
                               want.byte_value, i_out_item.byte_value);
                        fail_total++;
                    end
                    if (i_out_item.last !== want.last) begin
                        $error("last: expected %0b, actual %0b", want.last, i_out_item.last);
                        fail_total++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                step_sequencer(i_in_item);
        end
        o_fail_count <= fail_total;
        o_pending    <= expected_results.size();
        o_checked    <= checked_total;
    end

endmodule

/* tb/tb_dataflash_spi_command_sequencer_unit.sv */
// ----------------------------------------------------------------------------
// tb_dataflash_spi_command_sequencer_unit
// Plays flash and host towards the command sequencer: answers every transfer
// and data request it issues, slips in requests it must ignore, and varies the
// opcode and filler registers between runs. A separate checker predicts and
// compares every result item; this module only drives and gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_dataflash_spi_command_sequencer_unit;

    import dfsq_pkg::*;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int RANDOM_ITEMS  = 16;
    localparam int SETTINGS_RUNS = 4;
    // Results pass the input and result registers after their item; allow a margin on top
    localparam int SETTLE_CYCLES = 8;
    localparam logic [3:0][7:0] DATA_EXTREMES = {8'hFF, 8'h80, 8'h7F, 8'h00};

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [7:0]            i_cfg_data  = '0;
    logic                  i_in_valid  = 1'b0;
    t_in_item              i_in_item   = '0;
    logic                  i_out_stall = 1'b0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    t_out_item             o_out_item;

    int chk_fail_count;
    int chk_pending;
    int chk_checked;

    // Stimulus state
    logic       quiet       = 1'b0;
    logic       patterned   = 1'b0;
    int         pattern_pos = 0;
    int         stall_run   = 0;
    int         cycle_count = 0;
    int         groups_seen = 0;
    logic [2:0] reply_action = ACT_DONE;
    int         n_items   = 0;
    int         n_ignored = 0;
    int         n_reads   = 0;
    int         n_writes  = 0;
    int         n_refused = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    dataflash_spi_command_sequencer_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    dfsq_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_item    (i_in_item),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_item   (o_out_item),
        .o_fail_count (chk_fail_count),
        .o_pending    (chk_pending),
        .o_checked    (chk_checked)
    );

    // Receiver back-pressure: bursts of free-running and stalled cycles, mostly
    // short with the odd long stall; held off entirely during quiet runs.
    always @(posedge i_clk) begin : stall_gen
        int pick;
        if (stall_run != 0) begin
            stall_run <= stall_run - 1;
        end else if (quiet) begin
            i_out_stall <= 1'b0;
            stall_run   <= 16;
        end else begin
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                i_out_stall <= 1'b0;
                stall_run   <= $urandom_range(0, 7);
            end else if (pick < 9) begin
                i_out_stall <= 1'b1;
                stall_run   <= $urandom_range(0, 2);
            end else begin
                i_out_stall <= 1'b1;
                stall_run   <= $urandom_range(10, 40);
            end
        end
    end

    // Track the tail of each result group: its last action says what the
    // sequencer is waiting for next (SPI byte, host byte, or a new request).
    always @(posedge i_clk) begin
        if (o_out_valid && !i_out_stall) begin
            reply_action <= o_out_item.action;
            if (o_out_item.last)
                groups_seen <= groups_seen + 1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $error("cycle limit of %0d reached with %0d results outstanding",
                   CYCLE_LIMIT, chk_pending);
            $display("Verification failed");
            $finish;
        end
    end

    function automatic int idle_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 19);
        if (r < 12)
            return 0;
        if (r < 18)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Directed runs walk the byte extremes; random runs favour a ready status
    function automatic logic [7:0] next_data_byte(input logic ready_bias);
        logic [7:0] v;
        if (patterned) begin
            v           = DATA_EXTREMES[pattern_pos];
            pattern_pos = (pattern_pos + 1) % 4;
        end else begin
            v = 8'($urandom_range(0, 255));
            if (ready_bias && $urandom_range(0, 3) != 0)
                v[7] = 1'b1;
        end
        return v;
    endfunction

    function automatic t_in_item make_request(input logic [1:0] op, input int unsigned offset,
                                              input int unsigned length);
        t_in_item it;
        it.op     = op;
        it.offset = OFFSET_W'(offset);
        it.length = LEN_W'(length);
        it.data   = 8'($urandom_range(0, 255));
        return it;
    endfunction

    function automatic t_in_item random_request();
        int          r;
        int unsigned off;
        int unsigned len;
        logic [1:0]  op;
        r   = $urandom_range(0, 99);
        op  = $urandom_range(0, 1) ? OP_WRITE : OP_READ;
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 14) : $urandom_range(1, 6);
        if (r < 8)
            return make_request(op, $urandom_range(OFFSET_LIMIT + 1, 2**OFFSET_W - 1),
                                $urandom_range(0, 2**LEN_W - 1));
        if (r < 14)
            return make_request(OP_WRITE, $urandom_range(0, OFFSET_LIMIT), 0);
        if (r < 18)
            return make_request(OP_READ, $urandom_range(0, OFFSET_LIMIT), 0);
        // Bias towards the page end so writes roll over into the next page
        if (r < 45)
            off = $urandom_range(0, PAGE_COUNT - 1) * PAGE_BYTES + PAGE_BYTES
                  - $urandom_range(1, 4);
        else if (r < 52)
            off = OFFSET_LIMIT - $urandom_range(0, 3);
        else
            off = $urandom_range(0, OFFSET_LIMIT);
        return make_request(op, off, len);
    endfunction

    // An item the sequencer must drop in its present state
    function automatic t_in_item ignored_item(input logic [2:0] reply);
        t_in_item it;
        int       r;
        it = make_request(OP_READ, $urandom_range(0, 2**OFFSET_W - 1),
                          $urandom_range(0, 2**LEN_W - 1));
        r  = $urandom_range(0, 2);
        case (reply)
            ACT_NEED:
                it.op = (r == 0) ? OP_READ : (r == 1) ? OP_WRITE : OP_SPI_BYTE;
            ACT_DONE, ACT_REJECT:
                it.op = r[0] ? OP_SPI_BYTE : OP_HOST_BYTE;
            default:
                it.op = (r == 0) ? OP_READ : (r == 1) ? OP_WRITE : OP_HOST_BYTE;
        endcase
        return it;
    endfunction

    // Present one item and hold it until accepted; valid is left high so the
    // caller either follows on at once or drops it at this very edge.
    task automatic present(input t_in_item it);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_item  <= it;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic await_reply(input int target);
        i_in_valid <= 1'b0;
        while (groups_seen < target) @(posedge i_clk);
    endtask

    task automatic maybe_ignored(input logic [2:0] reply);
        if ($urandom_range(0, 9) == 0) begin
            present(ignored_item(reply));
            n_ignored++;
        end
    endtask

    // Run one request to completion, answering each transfer and data request
    task automatic converse(input t_in_item request);
        int       target;
        t_in_item it;
        if (request.offset > OFFSET_LIMIT)
            n_refused++;
        else if (request.op == OP_READ)
            n_reads++;
        else
            n_writes++;
        target = groups_seen + 1;
        present(request);
        n_items++;
        // A started request is busy polling: slip a dropped item in behind it
        if (request.offset <= OFFSET_LIMIT && !(request.op == OP_WRITE && request.length == '0))
            maybe_ignored(ACT_XFER);
        await_reply(target);
        while (reply_action != ACT_DONE && reply_action != ACT_REJECT) begin
            maybe_ignored(reply_action);
            it        = make_request(OP_SPI_BYTE, $urandom_range(0, 2**OFFSET_W - 1),
                                     $urandom_range(0, 2**LEN_W - 1));
            it.op     = (reply_action == ACT_NEED) ? OP_HOST_BYTE : OP_SPI_BYTE;
            it.data   = next_data_byte(it.op == OP_SPI_BYTE);
            target    = groups_seen + 1;
            present(it);
            n_items++;
            // A host byte always leaves the sequencer busy shifting it out
            if (it.op == OP_HOST_BYTE)
                maybe_ignored(ACT_XFER);
            await_reply(target);
        end
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index, input logic [7:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
    endtask

    // Drain every outstanding result, let the pipeline settle, then reprogram
    task automatic load_settings(input t_cfg s);
        while (chk_pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        write_register(CFG_STATUS_OP, s.status_opcode);
        write_register(CFG_READ_OP,   s.page_read_opcode);
        write_register(CFG_P2B_OP,    s.page_to_buffer_opcode);
        write_register(CFG_BWR_OP,    s.buffer_write_opcode);
        write_register(CFG_RWR_OP,    s.rewrite_opcode);
        write_register(CFG_FILLER,    s.filler_byte);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        t_cfg setting;
        int   budget;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: refusals, empty transfers, top of the address range with
        // page wrap, a write that rolls over into the next page; status and
        // data bytes cycle through their extremes so busy polls occur too.
        patterned = 1'b1;
        converse(make_request(OP_READ, 2**OFFSET_W - 1, 2**LEN_W - 1));
        converse(make_request(OP_WRITE, OFFSET_LIMIT + 1, 0));
        converse(make_request(OP_WRITE, 0, 0));
        converse(make_request(OP_READ, 0, 0));
        converse(make_request(OP_READ, OFFSET_LIMIT, 1));
        converse(make_request(OP_WRITE, OFFSET_LIMIT - 2, 3));
        patterned = 1'b0;

        // Random: one run per register setting, the all-ones one without idling
        for (int run = 0; run < SETTINGS_RUNS; run++) begin
            case (run)
                1:       setting = '0;
                2:       setting = '1;
                default: setting = '{8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))};
            endcase
            load_settings(setting);
            quiet <= (run == 2);
            budget = n_items + RANDOM_ITEMS / SETTINGS_RUNS;
            while (n_items < budget) begin
                maybe_ignored(ACT_DONE);
                converse(random_request());
            end
        end

        i_in_valid <= 1'b0;
        while (chk_pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Ran %0d reads, %0d writes and %0d refused requests (%0d items, %0d dropped)",
                 n_reads, n_writes, n_refused, n_items, n_ignored);
        $display("over %0d register settings; %0d result items compared",
                 SETTINGS_RUNS + 1, chk_checked);
        if (chk_fail_count == 0 && chk_pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/dfsq_pkg.sv
rtl/core/dfsq_cfg.sv
rtl/core/dfsq_engine.sv
rtl/core/dfsq_out.sv
rtl/core/dataflash_spi_command_sequencer_unit.sv
tb/dfsq_result_checker.sv
tb/tb_dataflash_spi_command_sequencer_unit.sv
